// ----- sv/snm_pkg.sv -----
// Shared types, constants and register codes of the Sobel normal-map unit.
package snm_pkg;

    localparam int GRAY_W = 8;
    localparam int CH_W   = 8;
    localparam int FW_W   = 11;
    localparam int FH_W   = 11;
    localparam int BS_W   = 12;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST   = 11'd208;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST  = 11'd208;
    localparam logic [BS_W-1:0] BUMP_STRENGTH_RST = 12'd256;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_BUMP_STRENGTH = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Gradient magnitude times strength, squared-sum and scaled slope widths.
    localparam int G_W  = 11;
    localparam int AG_W = 10;
    localparam int P_W  = 22;
    localparam int Q_W  = 22;
    localparam int TT_W = 30;

    // Blue encodes t = -255 * 65280.
    localparam logic [P_W-1:0] BLUE_P = 22'd65280;

    localparam logic [CH_W-1:0] BORDER_RG = 8'd127;
    localparam logic [CH_W-1:0] BORDER_B  = 8'd255;

    typedef struct packed {
        logic              cmd;
        logic [GRAY_W-1:0] gray;
    } pix_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_end;
    } nrm_t;

    typedef struct packed {
        logic [FW_W-1:0] frame_width;
        logic [FH_W-1:0] frame_height;
        logic [BS_W-1:0] bump_strength;
    } cfg_t;

endpackage

// ----- sv/sobel_normal_map_unit.sv -----
// Top level of the Sobel normal-map unit: line store, window, control and output register.
//
//  channel   direction  handshake            payload
//  pix       in         pix_valid/pix_stall  pix_data (cmd, gray)
//  nrm       out        nrm_valid/nrm_stall  nrm_data (red, green, blue, frame_end)
//  apb       in/out     psel/penable/pready  paddr, pwdata, prdata
//
// A pixel request that yields no result reads the line store, then writes it back.
// A border result passes the CALC and OUT states; an interior result also passes PREP
// and ENC, where the shared encoder runs 8 compare steps for each of red, green and blue.
// After reset the window and all positions are zero; the line store content is unknown.
// A new request is taken while a finished result waits in the output register.
module sobel_normal_map_unit #(
    parameter int MAX_WIDTH  = snm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = snm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pix_valid,
    output logic                        pix_stall,
    input  snm_pkg::pix_t               pix_data,
    output logic                        nrm_valid,
    input  logic                        nrm_stall,
    output snm_pkg::nrm_t               nrm_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [snm_pkg::ADDR_W-1:0]  paddr,
    input  logic [snm_pkg::DATA_W-1:0]  pwdata,
    output logic [snm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import snm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int BW = $clog2(MAX_WIDTH + 2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_ENC  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    cfg_t cfg;

    logic [2:0]        state_reg;
    logic [CW-1:0]     icol_reg;
    logic [CW-1:0]     ocol_reg;
    logic [RW-1:0]     orow_reg;
    logic [BW-1:0]     backlog_reg;
    logic [GRAY_W-1:0] win_reg [3][3];
    logic [GRAY_W-1:0] gray_reg;
    logic signed [G_W-1:0] gx_reg;
    logic signed [G_W-1:0] gy_reg;
    logic              fend_reg;
    logic [Q_W-1:0]    q_reg;
    logic [P_W-1:0]    px_reg;
    logic [P_W-1:0]    py_reg;
    logic              sx_reg;
    logic              sy_reg;
    logic [1:0]        chan_reg;
    logic              start_reg;
    logic [CH_W-1:0]   red_reg;
    logic [CH_W-1:0]   green_reg;
    logic [CH_W-1:0]   blue_reg;
    logic              out_valid_reg;
    nrm_t              out_reg;

    logic [WW-1:0]     w;
    logic [HW-1:0]     h;
    logic              accept;
    logic              slot_free;
    logic              ram_we;
    logic [2*GRAY_W-1:0] ram_rdata;
    logic [BW-1:0]     backlog_inc;
    logic              icol_last;
    logic              ocol_last;
    logic              orow_last;
    logic              interior;
    logic signed [G_W-1:0] gx;
    logic signed [G_W-1:0] gy;
    logic [AG_W-1:0]   ax;
    logic [AG_W-1:0]   ay;
    logic              enc_sign;
    logic [P_W-1:0]    enc_p;
    logic              enc_done;
    logic [CH_W-1:0]   enc_res;

    snm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Each entry holds {upper line, middle line} for one column.
    snm_ram #(
        .WIDTH (2*GRAY_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (icol_reg),
        .wdata ({ram_rdata[GRAY_W-1:0], gray_reg}),
        .re    (accept),
        .raddr (icol_reg),
        .rdata (ram_rdata)
    );

    snm_encoder u_enc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .sign  (enc_sign),
        .p     (enc_p),
        .q     (q_reg),
        .done  (enc_done),
        .res   (enc_res)
    );

    always_comb
    begin
        if (32'(cfg.frame_width) < 3)
        begin
            w = WW'(3);
        end
        else if (32'(cfg.frame_width) > MAX_WIDTH)
        begin
            w = WW'(MAX_WIDTH);
        end
        else
        begin
            w = WW'(cfg.frame_width);
        end
        if (32'(cfg.frame_height) < 3)
        begin
            h = HW'(3);
        end
        else if (32'(cfg.frame_height) > MAX_HEIGHT)
        begin
            h = HW'(MAX_HEIGHT);
        end
        else
        begin
            h = HW'(cfg.frame_height);
        end
    end

    assign pix_stall   = (state_reg != S_IDLE);
    assign accept      = pix_valid && !pix_stall;
    assign slot_free   = !out_valid_reg || !nrm_stall;
    assign ram_we      = (state_reg == S_RD);
    assign backlog_inc = backlog_reg + BW'(1);
    assign icol_last   = (32'(icol_reg) + 1) >= 32'(w);
    assign ocol_last   = (32'(ocol_reg) + 1) >= 32'(w);
    assign orow_last   = (32'(orow_reg) + 1) >= 32'(h);
    assign interior    = (ocol_reg != '0) && ((32'(ocol_reg) + 2) <= 32'(w))
                      && (orow_reg != '0) && ((32'(orow_reg) + 2) <= 32'(h));

    always_comb
    begin
        gx = ($signed({3'b0, win_reg[0][2]}) + $signed({2'b0, win_reg[1][2], 1'b0})
              + $signed({3'b0, win_reg[2][2]}))
           - ($signed({3'b0, win_reg[0][0]}) + $signed({2'b0, win_reg[1][0], 1'b0})
              + $signed({3'b0, win_reg[2][0]}));
        gy = ($signed({3'b0, win_reg[2][0]}) + $signed({2'b0, win_reg[2][1], 1'b0})
              + $signed({3'b0, win_reg[2][2]}))
           - ($signed({3'b0, win_reg[0][0]}) + $signed({2'b0, win_reg[0][1], 1'b0})
              + $signed({3'b0, win_reg[0][2]}));
        ax = gx_reg[G_W-1] ? AG_W'(-gx_reg) : AG_W'(gx_reg);
        ay = gy_reg[G_W-1] ? AG_W'(-gy_reg) : AG_W'(gy_reg);
    end

    always_comb
    begin
        unique case (chan_reg)
            CH_RED:
            begin
                enc_sign = sx_reg;
                enc_p    = px_reg;
            end
            CH_GREEN:
            begin
                enc_sign = sy_reg;
                enc_p    = py_reg;
            end
            default:
            begin
                enc_sign = 1'b1;
                enc_p    = BLUE_P;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            icol_reg      <= '0;
            ocol_reg      <= '0;
            orow_reg      <= '0;
            backlog_reg   <= '0;
            chan_reg      <= CH_RED;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            start_reg     <= (state_reg == S_PREP)
                          || (state_reg == S_ENC && enc_done && chan_reg != CH_BLUE);
            out_valid_reg <= (state_reg == S_OUT && slot_free) || (out_valid_reg && nrm_stall);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (pix_data.cmd == CMD_PIXEL)
                        begin
                            state_reg <= S_RD;
                        end
                        else if (backlog_reg != '0)
                        begin
                            state_reg <= S_CALC;
                        end
                    end
                end
                S_RD:
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        win_reg[r][0] <= win_reg[r][1];
                        win_reg[r][1] <= win_reg[r][2];
                    end
                    win_reg[0][2] <= ram_rdata[2*GRAY_W-1:GRAY_W];
                    win_reg[1][2] <= ram_rdata[GRAY_W-1:0];
                    win_reg[2][2] <= gray_reg;
                    icol_reg      <= icol_last ? '0 : icol_reg + CW'(1);
                    backlog_reg   <= backlog_inc;
                    state_reg     <= (32'(backlog_inc) > 32'(w)) ? S_CALC : S_IDLE;
                end
                S_CALC:
                begin
                    if (ocol_last)
                    begin
                        ocol_reg <= '0;
                        orow_reg <= orow_last ? '0 : orow_reg + RW'(1);
                    end
                    else
                    begin
                        ocol_reg <= ocol_reg + CW'(1);
                    end
                    backlog_reg <= backlog_reg - BW'(1);
                    state_reg   <= interior ? S_PREP : S_OUT;
                end
                S_PREP:
                begin
                    chan_reg  <= CH_RED;
                    state_reg <= S_ENC;
                end
                S_ENC:
                begin
                    if (enc_done)
                    begin
                        if (chan_reg == CH_BLUE)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            chan_reg <= chan_reg + 2'd1;
                        end
                    end
                end
                S_OUT:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gray_reg <= pix_data.gray;
        end
        if (state_reg == S_CALC)
        begin
            gx_reg    <= gx;
            gy_reg    <= gy;
            fend_reg  <= ocol_last && orow_last;
            red_reg   <= BORDER_RG;
            green_reg <= BORDER_RG;
            blue_reg  <= BORDER_B;
        end
        if (state_reg == S_PREP)
        begin
            q_reg  <= Q_W'(20'(ax) * 20'(ax)) + Q_W'(20'(ay) * 20'(ay)) + Q_W'(65025);
            px_reg <= P_W'(ax) * P_W'(cfg.bump_strength);
            py_reg <= P_W'(ay) * P_W'(cfg.bump_strength);
            sx_reg <= gx_reg[G_W-1];
            sy_reg <= gy_reg[G_W-1];
        end
        if (state_reg == S_ENC && enc_done)
        begin
            unique case (chan_reg)
                CH_RED:   red_reg   <= enc_res;
                CH_GREEN: green_reg <= enc_res;
                default:  blue_reg  <= enc_res;
            endcase
        end
        if (state_reg == S_OUT && slot_free)
        begin
            out_reg.red       <= red_reg;
            out_reg.green     <= green_reg;
            out_reg.blue      <= blue_reg;
            out_reg.frame_end <= fend_reg;
        end
    end

    assign nrm_valid = out_valid_reg;
    assign nrm_data  = out_reg;

    // Between requests the backlog never exceeds one full line.
    a_backlog_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> 32'(backlog_reg) <= MAX_WIDTH)
        else $error("backlog exceeds line length");

    // The encoder only finishes while the controller waits for it.
    a_enc_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        enc_done |-> state_reg == S_ENC)
        else $error("encoder finished outside encode phase");

    // A result that leaves the control path appears at the output next cycle.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && slot_free |=> nrm_valid)
        else $error("result not presented");

    // A drain request with nothing pending produces no work.
    a_empty_drain: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pix_data.cmd == CMD_DRAIN && backlog_reg == '0 |=> state_reg == S_IDLE)
        else $error("empty drain started work");

endmodule

// ----- sv/snm_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module snm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/snm_cfg.sv -----
// APB-style configuration registers of the normal-map unit.
module snm_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [snm_pkg::ADDR_W-1:0]  paddr,
    input  logic [snm_pkg::DATA_W-1:0]  pwdata,
    output logic [snm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output snm_pkg::cfg_t               cfg
);
    import snm_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width   <= FRAME_WIDTH_RST;
            cfg_reg.frame_height  <= FRAME_HEIGHT_RST;
            cfg_reg.bump_strength <= BUMP_STRENGTH_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_FRAME_WIDTH:   cfg_reg.frame_width   <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT:  cfg_reg.frame_height  <= pwdata[FH_W-1:0];
                REG_BUMP_STRENGTH: cfg_reg.bump_strength <= pwdata[BS_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_FRAME_WIDTH:   prdata = DATA_W'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT:  prdata = DATA_W'(cfg_reg.frame_height);
            REG_BUMP_STRENGTH: prdata = DATA_W'(cfg_reg.bump_strength);
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/snm_encoder.sv -----
// Bit-by-bit search of floor(127.5 - t/(512*sqrt(q))), saturated to 0..255.
module snm_encoder (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     sign,
    input  logic [snm_pkg::P_W-1:0]  p,
    input  logic [snm_pkg::Q_W-1:0]  q,
    output logic                     done,
    output logic [snm_pkg::CH_W-1:0] res
);
    import snm_pkg::*;

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_SQ   = 2'd1;
    localparam logic [1:0] E_A    = 2'd2;
    localparam logic [1:0] E_B    = 2'd3;

    logic [1:0]        st_reg;
    logic [TT_W-1:0]   tt_reg;
    logic [2*TT_W-1:0] tt2_reg;
    logic [15:0]       m_reg;
    logic              kneg_reg;
    logic              tneg_reg;
    logic              tzero_reg;
    logic [CH_W-1:0]   res_reg;
    logic [CH_W-1:0]   bit_reg;
    logic              done_reg;

    logic [CH_W-1:0]   k;
    logic signed [9:0] diff;
    logic [7:0]        d;
    logic [37:0]       prod;
    logic [2*TT_W-1:0] lhs;
    logic              meets;

    always_comb
    begin
        k    = res_reg | bit_reg;
        diff = 10'sd255 - $signed({1'b0, k, 1'b0});
        d    = diff[9] ? 8'(-diff) : diff[7:0];
        prod = 38'(m_reg) * 38'(q);
        lhs  = (2*TT_W)'({prod, 16'b0});
        // The sign of 255-2k selects which way the squared comparison goes.
        if (kneg_reg)
        begin
            meets = tneg_reg && (lhs <= tt2_reg);
        end
        else
        begin
            meets = tneg_reg || tzero_reg || (lhs >= tt2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= E_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (st_reg == E_B) && bit_reg[0];
            unique case (st_reg)
                E_IDLE:
                begin
                    if (start)
                    begin
                        st_reg <= E_SQ;
                    end
                end
                E_SQ:
                begin
                    st_reg <= E_A;
                end
                E_A:
                begin
                    st_reg <= E_B;
                end
                E_B:
                begin
                    if (bit_reg[0])
                    begin
                        st_reg <= E_IDLE;
                    end
                    else
                    begin
                        st_reg <= E_A;
                    end
                end
                default:
                begin
                    st_reg <= E_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    tt_reg    <= TT_W'({p, 8'b0}) - TT_W'(p);
                    tzero_reg <= (p == '0);
                    tneg_reg  <= sign && (p != '0);
                    res_reg   <= '0;
                    bit_reg   <= 8'h80;
                end
            end
            E_SQ:
            begin
                tt2_reg <= (2*TT_W)'(tt_reg) * (2*TT_W)'(tt_reg);
            end
            E_A:
            begin
                m_reg    <= 16'(d) * 16'(d);
                kneg_reg <= k[7];
            end
            E_B:
            begin
                if (meets)
                begin
                    res_reg <= res_reg | bit_reg;
                end
                bit_reg <= bit_reg >> 1;
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
